FILE: rtl/shrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrb_pkg
// Shared constants and types of the sample history ring buffer.
// ----------------------------------------------------------------------------
package shrb_pkg;

  localparam int DEPTH      = 64;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int VAL_W      = 16;
  localparam int TIME_W     = 32;
  localparam int LIM_W      = 7;
  localparam int POS_W      = 6;
  localparam int TOT_W      = 7;
  localparam int ENTRY_W    = VAL_W + TIME_W;
  localparam int CMP_W      = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int RESULT_CAP = 64;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // result descriptor, registered alongside the memory read data
  typedef struct packed {
    logic             valid;
    logic             present;
    logic             ack;
    logic             last;
    logic [POS_W-1:0] pos;
    logic [TOT_W-1:0] total;
  } rsp_t;

endpackage

FILE: rtl/sample_history_ring_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_history_ring_buffer_core
// Overwrite-oldest history of timestamped samples with oldest-first readout.
//
// channel  dir  tdata (low bit up)                          tuser / tlast
// s_axis   in   value[15:0] time[47:16] limit[54:48] pad    tuser: cmd
// m_axis   out  value[15:0] time[47:16] pos[53:48]          tuser: present, ack
//               total[60:54] pad                            tlast: last result
//
// a store yields one ack; a read returns one entry per cycle while credits
// allow (one result for an empty read), paced by the single ram port
// result data is registered in the ram, then passes a two-entry output queue
// output stalls hold issue through credits; s_axis_tready drops while a
// read is being streamed or the queue is out of credits
// reset clears pointers, fill count and queue; sample memory is not cleared
// ----------------------------------------------------------------------------
module sample_history_ring_buffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // sample_value, sample_time_ms, request_limit
  input  logic [0:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // entry_value, entry_time_ms, entry_position,
                                      // returned_total
  output logic [1:0]  m_axis_tuser,   // entry_present, is_write_ack
  output logic        m_axis_tlast    // last_result
);

  localparam int OUT_W = 64 + 2 + 1;

  logic                         ram_en, ram_we;
  logic [shrb_pkg::PTR_W-1:0]   ram_addr;
  logic [shrb_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  shrb_pkg::rsp_t               rsp;
  logic                         credit_ok;

  logic [OUT_W-1:0] slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop, push;
  logic [OUT_W-1:0] push_word;
  logic [2:0]       occ_next;

  shrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (s_axis_tuser[0]),
    .req_value_i (s_axis_tdata[15:0]),
    .req_time_i  (s_axis_tdata[47:16]),
    .req_limit_i (s_axis_tdata[54:48]),
    .credit_ok_i (credit_ok),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .rsp_o       (rsp)
  );

  shrb_ram #(
    .WIDTH (shrb_pkg::ENTRY_W),
    .DEPTH (shrb_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign pop  = (cnt_q != 2'd0) && m_axis_tready;
  assign push = rsp.valid;

  // entries in flight plus queued, after this cycle's pop
  assign occ_next  = {1'b0, cnt_q} + {2'b0, push} - {2'b0, pop};
  assign credit_ok = occ_next < 3'd2;

  always_comb begin
    push_word = '0;
    if (rsp.present) begin
      push_word[47:0] = ram_rdata;
    end
    push_word[53:48] = rsp.pos;
    push_word[60:54] = rsp.total;
    push_word[64]    = rsp.present;
    push_word[65]    = rsp.ack;
    push_word[66]    = rsp.last;
  end

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q + {1'b0, push} - {1'b0, pop};
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push) begin
      if ((cnt_q - {1'b0, pop}) == 2'd0) begin
        slot0_d = push_word;
      end else begin
        slot1_d = push_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = slot0_q[63:0];
  assign m_axis_tuser  = slot0_q[65:64];
  assign m_axis_tlast  = slot0_q[66];

endmodule

FILE: rtl/shrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrb_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module shrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/shrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shrb_ctrl
// Request sequencer: pointer and fill bookkeeping, memory access issue and
// result descriptors for the output stage.
// ----------------------------------------------------------------------------
module shrb_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  logic                                req_cmd_i,
  input  logic signed [shrb_pkg::VAL_W-1:0]   req_value_i,
  input  logic        [shrb_pkg::TIME_W-1:0]  req_time_i,
  input  logic        [shrb_pkg::LIM_W-1:0]   req_limit_i,
  input  logic                                credit_ok_i,
  output logic                                ram_en_o,
  output logic                                ram_we_o,
  output logic        [shrb_pkg::PTR_W-1:0]   ram_addr_o,
  output logic        [shrb_pkg::ENTRY_W-1:0] ram_wdata_o,
  output shrb_pkg::rsp_t                      rsp_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                         state_q, state_d;
  logic [shrb_pkg::PTR_W-1:0]   wp_q, wp_d;
  logic [shrb_pkg::CNT_W-1:0]   fill_q, fill_d;
  logic [shrb_pkg::PTR_W-1:0]   cursor_q, cursor_d;
  logic [shrb_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [shrb_pkg::TOT_W-1:0]   total_q, total_d;
  shrb_pkg::rsp_t               rsp_q, rsp_d;

  logic                         accept;
  logic                         full;
  logic [shrb_pkg::CMP_W-1:0]   lim_ext, fill_ext, min_ext;
  logic [shrb_pkg::TOT_W-1:0]   total_new;
  logic [shrb_pkg::PTR_W-1:0]   start_slot;
  logic                         read_last;

  function automatic logic [shrb_pkg::PTR_W-1:0] next_slot(
    input logic [shrb_pkg::PTR_W-1:0] slot
  );
    if (slot == shrb_pkg::PTR_W'(shrb_pkg::DEPTH - 1)) begin
      return '0;
    end
    return slot + shrb_pkg::PTR_W'(1);
  endfunction

  assign req_ready_o = (state_q == ST_IDLE) && credit_ok_i;
  assign accept      = req_valid_i && req_ready_o;
  assign full        = (fill_q == shrb_pkg::CNT_W'(shrb_pkg::DEPTH));

  always_comb begin
    lim_ext  = shrb_pkg::CMP_W'(req_limit_i);
    fill_ext = shrb_pkg::CMP_W'(fill_q);
    min_ext  = (fill_ext < lim_ext) ? fill_ext : lim_ext;
    if (min_ext > shrb_pkg::CMP_W'(shrb_pkg::RESULT_CAP)) begin
      total_new = shrb_pkg::TOT_W'(shrb_pkg::RESULT_CAP);
    end else begin
      total_new = min_ext[shrb_pkg::TOT_W-1:0];
    end
  end

  assign start_slot = full ? wp_q : '0;
  assign read_last  = ({1'b0, pos_q} + shrb_pkg::TOT_W'(1)) == total_q;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    cursor_d    = cursor_q;
    pos_d       = pos_q;
    total_d     = total_q;
    rsp_d       = '0;
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = wp_q;
    ram_wdata_o = {req_time_i, req_value_i};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_cmd_i == shrb_pkg::CMD_STORE) begin
            ram_en_o  = 1'b1;
            ram_we_o  = 1'b1;
            wp_d      = next_slot(wp_q);
            if (!full) begin
              fill_d = fill_q + shrb_pkg::CNT_W'(1);
            end
            rsp_d.valid = 1'b1;
            rsp_d.ack   = 1'b1;
            rsp_d.last  = 1'b1;
          end else if (total_new == '0) begin
            rsp_d.valid = 1'b1;
            rsp_d.last  = 1'b1;
          end else begin
            // first entry is read in the accept cycle
            ram_en_o      = 1'b1;
            ram_addr_o    = start_slot;
            cursor_d      = next_slot(start_slot);
            pos_d         = shrb_pkg::POS_W'(1);
            total_d       = total_new;
            rsp_d.valid   = 1'b1;
            rsp_d.present = 1'b1;
            rsp_d.total   = total_new;
            rsp_d.last    = (total_new == shrb_pkg::TOT_W'(1));
            if (total_new != shrb_pkg::TOT_W'(1)) begin
              state_d = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        if (credit_ok_i) begin
          ram_en_o      = 1'b1;
          ram_addr_o    = cursor_q;
          cursor_d      = next_slot(cursor_q);
          pos_d         = pos_q + shrb_pkg::POS_W'(1);
          rsp_d.valid   = 1'b1;
          rsp_d.present = 1'b1;
          rsp_d.pos     = pos_q;
          rsp_d.total   = total_q;
          rsp_d.last    = read_last;
          if (read_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wp_q     <= '0;
      fill_q   <= '0;
      cursor_q <= '0;
      pos_q    <= '0;
      total_q  <= '0;
      rsp_q    <= '0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      cursor_q <= cursor_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
      rsp_q    <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: dv/tb_sample_history_ring_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_history_ring_buffer_core
// Self-checking bench for the sample history ring buffer. A queue of store
// and read requests, with a directed opening and a long random tail, feeds a
// stream driver. A history model tracks the stored samples, write pointer and
// fill count, and queues every expected ack or history entry. The monitor
// compares each result field by field. Both sides idle at random, and the
// receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_sample_history_ring_buffer_core;

  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 440;

  typedef struct packed {
    logic                        cmd;
    logic [shrb_pkg::VAL_W-1:0]  value;
    logic [shrb_pkg::TIME_W-1:0] stamp;
    logic [shrb_pkg::LIM_W-1:0]  limit;
  } request_t;

  typedef struct packed {
    logic [shrb_pkg::VAL_W-1:0]  value;
    logic [shrb_pkg::TIME_W-1:0] stamp;
    logic [shrb_pkg::POS_W-1:0]  pos;
    logic [shrb_pkg::TOT_W-1:0]  total;
    logic                        present;
    logic                        ack;
    logic                        last;
  } history_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;   // sample_value, sample_time_ms, request_limit
  logic [0:0]  s_axis_tuser  = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // entry_value, entry_time_ms, entry_position,
                                     // returned_total
  logic [1:0]  m_axis_tuser;         // entry_present, is_write_ack
  logic        m_axis_tlast;         // last_result

  request_t        pending_requests[$];
  history_result_t expected_entries[$];

  logic [shrb_pkg::VAL_W-1:0]  hist_value[shrb_pkg::DEPTH];
  logic [shrb_pkg::TIME_W-1:0] hist_stamp[shrb_pkg::DEPTH];
  int                          hist_wr_ptr = 0;
  int                          hist_fill   = 0;

  int n_items     = 0;
  int n_accepted  = 0;
  int n_results   = 0;
  int n_errors    = 0;
  int idle_cycles = 0;

  int src_gap;
  bit src_steady;
  int snk_stall;
  bit snk_steady;
  bit hold_done;

  sample_history_ring_buffer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_store(input logic [shrb_pkg::VAL_W-1:0] value,
                           input logic [shrb_pkg::TIME_W-1:0] stamp);
    request_t req;
    req.cmd   = shrb_pkg::CMD_STORE;
    req.value = value;
    req.stamp = stamp;
    req.limit = shrb_pkg::LIM_W'($urandom());
    pending_requests.push_back(req);
    n_items++;
  endtask

  task automatic add_read(input logic [shrb_pkg::LIM_W-1:0] limit);
    request_t req;
    req.cmd   = shrb_pkg::CMD_READ;
    req.value = shrb_pkg::VAL_W'($urandom());
    req.stamp = $urandom();
    req.limit = limit;
    pending_requests.push_back(req);
    n_items++;
  endtask

  // history model: updates the store and queues the results of one request
  task automatic predict_history(input logic cmd,
                                 input logic [shrb_pkg::VAL_W-1:0] value,
                                 input logic [shrb_pkg::TIME_W-1:0] stamp,
                                 input logic [shrb_pkg::LIM_W-1:0] limit);
    history_result_t res;
    int total;
    int slot;
    res = '0;
    if (cmd == shrb_pkg::CMD_STORE) begin
      hist_value[hist_wr_ptr] = value;
      hist_stamp[hist_wr_ptr] = stamp;
      hist_wr_ptr = (hist_wr_ptr + 1) % shrb_pkg::DEPTH;
      if (hist_fill < shrb_pkg::DEPTH) hist_fill++;
      res.ack  = 1'b1;
      res.last = 1'b1;
      expected_entries.push_back(res);
    end else begin
      total = (int'(limit) < hist_fill) ? int'(limit) : hist_fill;
      if (total > shrb_pkg::RESULT_CAP) total = shrb_pkg::RESULT_CAP;
      if (total == 0) begin
        res.last = 1'b1;
        expected_entries.push_back(res);
      end else begin
        // oldest entry sits at slot 0 until the buffer wraps
        slot = (hist_fill < shrb_pkg::DEPTH) ? 0 : hist_wr_ptr;
        for (int i = 0; i < total; i++) begin
          res.value   = hist_value[slot];
          res.stamp   = hist_stamp[slot];
          res.pos     = shrb_pkg::POS_W'(i);
          res.total   = shrb_pkg::TOT_W'(total);
          res.present = 1'b1;
          res.ack     = 1'b0;
          res.last    = (i == total - 1);
          expected_entries.push_back(res);
          slot = (slot + 1) % shrb_pkg::DEPTH;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap    = 0;
      src_steady = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_history(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[47:16],
                        s_axis_tdata[54:48]);
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          nxt = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, nxt.limit, nxt.stamp, nxt.value};
          s_axis_tuser  <= nxt.cmd;
          if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
          src_gap = pick_gap(src_steady);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    history_result_t want;
    if (!rst_ni) begin
      n_results <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      n_results <= n_results + 1;
      if (expected_entries.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, got tdata %0h tuser %0b tlast %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = expected_entries.pop_front();
        check_field("entry_value", 32'(want.value), 32'(m_axis_tdata[15:0]));
        check_field("entry_time_ms", want.stamp, m_axis_tdata[47:16]);
        check_field("entry_position", 32'(want.pos), 32'(m_axis_tdata[53:48]));
        check_field("returned_total", 32'(want.total), 32'(m_axis_tdata[60:54]));
        check_field("entry_present", 32'(want.present), 32'(m_axis_tuser[0]));
        check_field("is_write_ack", 32'(want.ack), 32'(m_axis_tuser[1]));
        check_field("last_result", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // receiver ready with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_stall  = 0;
      snk_steady = 1'b0;
      hold_done  = 1'b0;
    end else begin
      if (!hold_done && n_results >= HOLD_AFTER) begin
        hold_done = 1'b1;
        snk_stall = HOLD_CYCLES;
      end
      if (snk_stall > 0) begin
        snk_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 79) == 0) snk_steady = !snk_steady;
        snk_stall = pick_gap(snk_steady);
      end
    end
  end

  // watchdog on cycles without any request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb_sample_history_ring_buffer_core NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int r;
    // empty buffer, then extremes of value and timestamp
    add_read(7'd5);
    add_read(7'd0);
    add_store(16'h8000, 32'h0000_0000);
    add_store(16'h7fff, 32'hffff_ffff);
    add_store(16'h0000, 32'h0000_0001);
    add_store(16'hffff, 32'h8000_0000);
    add_read(7'd0);
    add_read(7'd1);
    add_read(7'd4);
    add_read(7'd127);
    add_read(7'd64);
    add_store(16'h0001, $urandom());
    add_read(7'd3);
    add_read(7'd65);
    add_store(16'h5555, 32'haaaa_aaaa);
    add_store(16'haaaa, 32'h5555_5555);
    add_read(7'd2);
    add_read(7'd6);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        add_store(shrb_pkg::VAL_W'($urandom()), $urandom());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10)      add_read(7'd0);
        else if (r < 20) add_read(7'd64);
        else if (r < 30) add_read(shrb_pkg::LIM_W'($urandom_range(65, 127)));
        else if (r < 45) add_read(7'd1);
        else             add_read(shrb_pkg::LIM_W'($urandom_range(1, 64)));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_items) @(posedge clk_i);
    while (expected_entries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0 && expected_entries.size() == 0) begin
      $display("tb_sample_history_ring_buffer_core OK");
    end else begin
      $display("tb_sample_history_ring_buffer_core NOT OK");
    end
    $finish;
  end

endmodule
